[rtl/rau_pkg.sv]
`timescale 1ns / 1ps
package rau_pkg;

    localparam int WIDTH = 32;
    localparam int MAG_W = 64;

    // Request opcodes
    localparam logic [3:0] OP_NORM  = 4'd0;
    localparam logic [3:0] OP_ADD   = 4'd1;
    localparam logic [3:0] OP_SUB   = 4'd2;
    localparam logic [3:0] OP_MUL   = 4'd3;
    localparam logic [3:0] OP_DIV   = 4'd4;
    localparam logic [3:0] OP_MOD   = 4'd5;
    localparam logic [3:0] OP_NEG   = 4'd6;
    localparam logic [3:0] OP_RECIP = 4'd7;
    localparam logic [3:0] OP_INC   = 4'd8;
    localparam logic [3:0] OP_DEC   = 4'd9;
    localparam logic [3:0] OP_CMP   = 4'd10;

    // Status codes
    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_ZERO = 2'd1;
    localparam logic [1:0] ST_OVF  = 2'd2;

    // Compare codes
    localparam logic [1:0] CMP_LT = 2'd0;
    localparam logic [1:0] CMP_EQ = 2'd1;
    localparam logic [1:0] CMP_GT = 2'd2;

    // Sign-magnitude value
    typedef struct packed {
        logic             neg;
        logic [MAG_W-1:0] mag;
    } sm_t;

    // Divider request from the sequencer
    typedef struct packed {
        logic             start;
        logic [MAG_W-1:0] dividend;
        logic [MAG_W-1:0] divisor;
    } div_req_t;

    // Divider reply to the sequencer
    typedef struct packed {
        logic             done;
        logic [MAG_W-1:0] quot;
        logic [MAG_W-1:0] rem;
    } div_rsp_t;

    function automatic sm_t sm_add(input sm_t x, input sm_t y);
        sm_t r;
        if (x.neg == y.neg) begin
            r.neg = x.neg;
            r.mag = x.mag + y.mag;
        end
        else if (x.mag >= y.mag) begin
            r.neg = x.neg;
            r.mag = x.mag - y.mag;
        end
        else begin
            r.neg = y.neg;
            r.mag = y.mag - x.mag;
        end
        r.neg = r.neg && (r.mag != '0);
        return r;
    endfunction

endpackage

[rtl/rau_div.sv]
`timescale 1ns / 1ps
module rau_div
(
    input  logic              clk,
    input  logic              rst_n,
    input  rau_pkg::div_req_t req,
    output rau_pkg::div_rsp_t rsp
);
    import rau_pkg::*;

    localparam int CNT_W = $clog2(MAG_W);

    logic             busy_reg;
    logic             done_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [MAG_W-1:0] rem_reg;
    logic [MAG_W-1:0] quo_reg;
    logic [MAG_W-1:0] dvs_reg;
    logic [MAG_W:0]   trial;
    logic [MAG_W:0]   diff;

    // One restoring step per cycle: shift in the next dividend bit, try subtract
    assign trial = {rem_reg, quo_reg[MAG_W-1]};
    assign diff  = trial - {1'b0, dvs_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(MAG_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            rem_reg <= '0;
            quo_reg <= req.dividend;
            dvs_reg <= req.divisor;
        end
        else if (busy_reg)
        begin
            if (!diff[MAG_W])
            begin
                rem_reg <= diff[MAG_W-1:0];
                quo_reg <= {quo_reg[MAG_W-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= trial[MAG_W-1:0];
                quo_reg <= {quo_reg[MAG_W-2:0], 1'b0};
            end
        end
    end

    assign rsp.done = done_reg;
    assign rsp.quot = quo_reg;
    assign rsp.rem  = rem_reg;

endmodule

[rtl/rational_arithmetic_unit.sv]
`timescale 1ns / 1ps
// Rational arithmetic unit.
// Input channel (s_*): one transaction carries an opcode on s_tuser and the
// two fractions A = a_num/a_den and B = b_num/b_den on s_tdata. Output channel
// (m_*): one transaction per request with the reduced fraction, a compare
// code and a status.
// A, and B for binary opcodes, are normalized (sign on the numerator, reduced
// by the GCD) before the operation; the results of binary arithmetic and of
// increment and decrement are reduced again, and every result is range
// checked. One 64-step divider does all GCD and quotient work. A request runs
// up to three reductions (none for an illegal opcode or a zero denominator)
// plus the multiply steps of the binary operations.
// Throughput: one request at a time; s_tready is high only while the
// sequencer is idle.
// The result sits in an output register; the next request is accepted while
// it waits. If a new result is ready while the old one is still stalled,
// the sequencer holds until the receiver takes the old one.
// Reset clears the sequencer and the output valid; no clearing pass.
module rational_arithmetic_unit
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [127:0] s_tdata,  // a_num[31:0], a_den[63:32], b_num[95:64], b_den[127:96]
    input  logic [7:0]   s_tuser,  // req_type[3:0], zero fill [7:4]
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [71:0]  m_tdata   // res_num[31:0], res_den[62:32], cmp_code[64:63],
                                   // status[66:65], zero fill [71:67]
);
    import rau_pkg::*;

    // Sequencer states
    localparam logic [4:0] S_IDLE   = 5'd0;
    localparam logic [4:0] S_CHECK  = 5'd1;
    localparam logic [4:0] S_RSTART = 5'd2;
    localparam logic [4:0] S_RGCD   = 5'd3;
    localparam logic [4:0] S_RGCDW  = 5'd4;
    localparam logic [4:0] S_RDIVN  = 5'd5;
    localparam logic [4:0] S_RDIVNW = 5'd6;
    localparam logic [4:0] S_RDIVD  = 5'd7;
    localparam logic [4:0] S_RDIVDW = 5'd8;
    localparam logic [4:0] S_RDONE  = 5'd9;
    localparam logic [4:0] S_OP     = 5'd10;
    localparam logic [4:0] S_M1     = 5'd11;
    localparam logic [4:0] S_M2     = 5'd12;
    localparam logic [4:0] S_M3     = 5'd13;
    localparam logic [4:0] S_COMB   = 5'd14;
    localparam logic [4:0] S_MODW   = 5'd15;
    localparam logic [4:0] S_EMIT   = 5'd16;

    // Which reduction is running
    localparam logic [1:0] PH_A = 2'd0;
    localparam logic [1:0] PH_B = 2'd1;
    localparam logic [1:0] PH_R = 2'd2;

    localparam logic [MAG_W-1:0] LIM = MAG_W'(1) << (WIDTH - 1);

    logic [4:0]       state_reg;
    logic [1:0]       phase_reg;
    logic             m_valid_reg;
    logic [71:0]      m_data_reg;

    logic [3:0]       op_reg;
    logic [1:0]       status_reg;
    logic [1:0]       cmp_reg;
    // raw operands as sign and magnitude
    logic             an_neg_reg, ad_neg_reg, bn_neg_reg, bd_neg_reg;
    logic [31:0]      an_mag_reg, ad_mag_reg, bn_mag_reg, bd_mag_reg;
    // reduced operands
    logic             a_neg_reg, b_neg_reg;
    logic [31:0]      a_num_reg, a_den_reg, b_num_reg, b_den_reg;
    // reduction working set
    logic             rn_neg_reg, rd_neg_reg;
    logic [MAG_W-1:0] rn_mag_reg, rd_mag_reg, gx_reg, gy_reg;
    // products
    logic [MAG_W-1:0] p1_reg, p2_reg, p3_reg;
    // result
    logic             r_neg_reg;
    logic [MAG_W-1:0] r_num_reg, r_den_reg;

    logic [31:0]      mul_x, mul_y;
    logic [MAG_W-1:0] prod;
    div_req_t         dreq;
    div_rsp_t         drsp;
    logic             binary;
    logic             red_neg;
    sm_t              sum_nd;
    sm_t              cmp_diff;
    logic [MAG_W-1:0] mod_adj;
    logic             ovf;
    logic             bad;
    logic [MAG_W-1:0] out_num;
    logic [1:0]       out_status;
    logic             out_take;

    rau_div u_div
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (dreq),
        .rsp   (drsp)
    );

    assign binary = (op_reg >= OP_ADD && op_reg <= OP_MOD) || op_reg == OP_CMP;
    assign red_neg = rn_neg_reg ^ rd_neg_reg;

    // Shared multiplier: operands picked by the step
    always_comb
    begin
        mul_x = a_den_reg;
        mul_y = b_den_reg;
        unique case (state_reg)
            S_M1:
            begin
                mul_x = a_num_reg;
                mul_y = (op_reg == OP_MUL) ? b_num_reg : b_den_reg;
            end
            S_M2:
            begin
                mul_x = a_den_reg;
                mul_y = (op_reg == OP_MUL) ? b_den_reg : b_num_reg;
            end
            default:
            begin
                mul_x = a_den_reg;
                mul_y = b_den_reg;
            end
        endcase
    end
    assign prod = MAG_W'(mul_x) * MAG_W'(mul_y);

    // Divider requests: Euclid steps, quotient by the GCD, modulo
    always_comb
    begin
        dreq.start    = 1'b0;
        dreq.dividend = gx_reg;
        dreq.divisor  = gy_reg;
        unique case (state_reg)
            S_RGCD:
            begin
                dreq.start = (gy_reg != '0);
            end
            S_RDIVN:
            begin
                dreq.start    = 1'b1;
                dreq.dividend = rn_mag_reg;
                dreq.divisor  = gx_reg;
            end
            S_RDIVD:
            begin
                dreq.start    = 1'b1;
                dreq.dividend = rd_mag_reg;
                dreq.divisor  = gx_reg;
            end
            S_COMB:
            begin
                dreq.start    = (op_reg == OP_MOD);
                dreq.dividend = p1_reg;
                dreq.divisor  = p2_reg;
            end
            default:
            begin
                dreq.start = 1'b0;
            end
        endcase
    end

    // Add / subtract / increment / decrement numerator
    always_comb
    begin
        sm_t x, y;
        if (op_reg == OP_INC || op_reg == OP_DEC)
        begin
            x.neg  = a_neg_reg;
            x.mag  = MAG_W'(a_num_reg);
            y.neg  = (op_reg == OP_DEC);
            y.mag  = MAG_W'(a_den_reg);
        end
        else
        begin
            x.neg  = a_neg_reg;
            x.mag  = p1_reg;
            y.neg  = b_neg_reg ^ (op_reg == OP_SUB);
            y.mag  = p2_reg;
        end
        sum_nd = sm_add(x, y);
    end

    always_comb
    begin
        sm_t x, y;
        x.neg    = a_neg_reg;
        x.mag    = p1_reg;
        y.neg    = !b_neg_reg;
        y.mag    = p2_reg;
        cmp_diff = sm_add(x, y);
    end

    // Floored remainder takes the divisor's sign
    assign mod_adj = (drsp.rem != '0 && a_neg_reg != b_neg_reg) ? p2_reg - drsp.rem
                                                                  : drsp.rem;

    // Range check and final formatting
    assign ovf = (r_neg_reg ? (r_num_reg > LIM) : (r_num_reg > LIM - 1'b1))
               || (r_den_reg > LIM - 1'b1);
    assign bad = (status_reg != ST_OK) || ovf;
    assign out_num = r_neg_reg ? (MAG_W'(0) - r_num_reg) : r_num_reg;
    assign out_status = (status_reg != ST_OK) ? status_reg : (ovf ? ST_OVF : ST_OK);
    assign out_take = !m_valid_reg || m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            // Drop the valid once taken, unless a new result loads this cycle
            if (m_valid_reg && m_tready && state_reg != S_EMIT)
            begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (s_tvalid)
                    begin
                        state_reg <= S_CHECK;
                    end
                end
                S_CHECK:
                begin
                    if (op_reg > OP_CMP || ad_mag_reg == '0 || (binary && bd_mag_reg == '0))
                    begin
                        state_reg <= S_EMIT;
                    end
                    else
                    begin
                        state_reg <= S_RSTART;
                    end
                end
                S_RSTART:
                begin
                    state_reg <= (rn_mag_reg == '0) ? S_RDONE : S_RGCD;
                end
                S_RGCD:
                begin
                    state_reg <= (gy_reg == '0) ? S_RDIVN : S_RGCDW;
                end
                S_RGCDW:
                begin
                    if (drsp.done)
                    begin
                        state_reg <= S_RGCD;
                    end
                end
                S_RDIVN:
                begin
                    state_reg <= S_RDIVNW;
                end
                S_RDIVNW:
                begin
                    if (drsp.done)
                    begin
                        state_reg <= S_RDIVD;
                    end
                end
                S_RDIVD:
                begin
                    state_reg <= S_RDIVDW;
                end
                S_RDIVDW:
                begin
                    if (drsp.done)
                    begin
                        state_reg <= S_RDONE;
                    end
                end
                S_RDONE:
                begin
                    if (phase_reg == PH_A && binary)
                    begin
                        state_reg <= S_RSTART;
                    end
                    else if (phase_reg == PH_R)
                    begin
                        state_reg <= S_EMIT;
                    end
                    else
                    begin
                        state_reg <= S_OP;
                    end
                end
                S_OP:
                begin
                    if (op_reg == OP_INC || op_reg == OP_DEC)
                    begin
                        state_reg <= S_RSTART;
                    end
                    else if (op_reg == OP_NORM || op_reg == OP_NEG || op_reg == OP_RECIP)
                    begin
                        state_reg <= S_EMIT;
                    end
                    else if ((op_reg == OP_DIV || op_reg == OP_MOD) && b_num_reg == '0)
                    begin
                        state_reg <= S_EMIT;
                    end
                    else
                    begin
                        state_reg <= S_M1;
                    end
                end
                S_M1:
                begin
                    state_reg <= S_M2;
                end
                S_M2:
                begin
                    state_reg <= S_M3;
                end
                S_M3:
                begin
                    state_reg <= S_COMB;
                end
                S_COMB:
                begin
                    if (op_reg == OP_MOD)
                    begin
                        state_reg <= S_MODW;
                    end
                    else if (op_reg == OP_CMP)
                    begin
                        state_reg <= S_EMIT;
                    end
                    else
                    begin
                        state_reg <= S_RSTART;
                    end
                end
                S_MODW:
                begin
                    if (drsp.done)
                    begin
                        state_reg <= S_RSTART;
                    end
                end
                S_EMIT:
                begin
                    if (out_take)
                    begin
                        m_valid_reg <= 1'b1;
                        state_reg   <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                op_reg     <= s_tuser[3:0];
                an_neg_reg <= s_tdata[31];
                an_mag_reg <= s_tdata[31] ? 32'(-s_tdata[31:0]) : s_tdata[31:0];
                ad_neg_reg <= s_tdata[63];
                ad_mag_reg <= s_tdata[63] ? 32'(-s_tdata[63:32]) : s_tdata[63:32];
                bn_neg_reg <= s_tdata[95];
                bn_mag_reg <= s_tdata[95] ? 32'(-s_tdata[95:64]) : s_tdata[95:64];
                bd_neg_reg <= s_tdata[127];
                bd_mag_reg <= s_tdata[127] ? 32'(-s_tdata[127:96]) : s_tdata[127:96];
                cmp_reg    <= CMP_LT;
                status_reg <= ST_OK;
                r_neg_reg  <= 1'b0;
                r_num_reg  <= '0;
                r_den_reg  <= MAG_W'(1);
            end
            S_CHECK:
            begin
                if (op_reg <= OP_CMP && (ad_mag_reg == '0 || (binary && bd_mag_reg == '0)))
                begin
                    status_reg <= ST_ZERO;
                end
                phase_reg  <= PH_A;
                rn_neg_reg <= an_neg_reg;
                rn_mag_reg <= MAG_W'(an_mag_reg);
                rd_neg_reg <= ad_neg_reg;
                rd_mag_reg <= MAG_W'(ad_mag_reg);
            end
            S_RSTART:
            begin
                if (rn_mag_reg == '0)
                begin
                    rn_neg_reg <= 1'b0;
                    rd_neg_reg <= 1'b0;
                    rd_mag_reg <= MAG_W'(1);
                end
                gx_reg <= rn_mag_reg;
                gy_reg <= rd_mag_reg;
            end
            S_RGCDW:
            begin
                if (drsp.done)
                begin
                    gx_reg <= gy_reg;
                    gy_reg <= drsp.rem;
                end
            end
            S_RDIVNW:
            begin
                if (drsp.done)
                begin
                    rn_mag_reg <= drsp.quot;
                end
            end
            S_RDIVDW:
            begin
                if (drsp.done)
                begin
                    rd_mag_reg <= drsp.quot;
                end
            end
            S_RDONE:
            begin
                unique case (phase_reg)
                    PH_A:
                    begin
                        a_neg_reg  <= red_neg;
                        a_num_reg  <= rn_mag_reg[31:0];
                        a_den_reg  <= rd_mag_reg[31:0];
                        phase_reg  <= PH_B;
                        rn_neg_reg <= bn_neg_reg;
                        rn_mag_reg <= MAG_W'(bn_mag_reg);
                        rd_neg_reg <= bd_neg_reg;
                        rd_mag_reg <= MAG_W'(bd_mag_reg);
                    end
                    PH_B:
                    begin
                        b_neg_reg <= red_neg;
                        b_num_reg <= rn_mag_reg[31:0];
                        b_den_reg <= rd_mag_reg[31:0];
                    end
                    default:
                    begin
                        r_neg_reg <= red_neg;
                        r_num_reg <= rn_mag_reg;
                        r_den_reg <= rd_mag_reg;
                    end
                endcase
            end
            S_OP:
            begin
                phase_reg <= PH_R;
                case (op_reg)
                    OP_NORM, OP_NEG:
                    begin
                        r_neg_reg <= (op_reg == OP_NEG) ? (a_num_reg != '0 && !a_neg_reg)
                                                        : a_neg_reg;
                        r_num_reg <= MAG_W'(a_num_reg);
                        r_den_reg <= MAG_W'(a_den_reg);
                    end
                    OP_RECIP:
                    begin
                        if (a_num_reg == '0)
                        begin
                            status_reg <= ST_ZERO;
                        end
                        else
                        begin
                            r_neg_reg <= a_neg_reg;
                            r_num_reg <= MAG_W'(a_den_reg);
                            r_den_reg <= MAG_W'(a_num_reg);
                        end
                    end
                    OP_DIV, OP_MOD:
                    begin
                        if (b_num_reg == '0)
                        begin
                            status_reg <= ST_ZERO;
                        end
                    end
                    OP_INC, OP_DEC:
                    begin
                        rn_neg_reg <= sum_nd.neg;
                        rn_mag_reg <= sum_nd.mag;
                        rd_neg_reg <= 1'b0;
                        rd_mag_reg <= MAG_W'(a_den_reg);
                    end
                    default:
                    begin
                        rn_neg_reg <= rn_neg_reg;
                    end
                endcase
            end
            S_M1:
            begin
                p1_reg <= prod;
            end
            S_M2:
            begin
                p2_reg <= prod;
            end
            S_M3:
            begin
                p3_reg <= prod;
            end
            S_COMB:
            begin
                case (op_reg)
                    OP_ADD, OP_SUB:
                    begin
                        rn_neg_reg <= sum_nd.neg;
                        rn_mag_reg <= sum_nd.mag;
                        rd_neg_reg <= 1'b0;
                        rd_mag_reg <= p3_reg;
                    end
                    OP_MUL:
                    begin
                        rn_neg_reg <= a_neg_reg ^ b_neg_reg;
                        rn_mag_reg <= p1_reg;
                        rd_neg_reg <= 1'b0;
                        rd_mag_reg <= p2_reg;
                    end
                    OP_DIV:
                    begin
                        rn_neg_reg <= a_neg_reg;
                        rn_mag_reg <= p1_reg;
                        rd_neg_reg <= b_neg_reg;
                        rd_mag_reg <= p2_reg;
                    end
                    OP_CMP:
                    begin
                        if (cmp_diff.mag == '0)
                        begin
                            cmp_reg <= CMP_EQ;
                        end
                        else
                        begin
                            cmp_reg <= cmp_diff.neg ? CMP_LT : CMP_GT;
                        end
                    end
                    default:
                    begin
                        rd_neg_reg <= 1'b0;
                        rd_mag_reg <= p3_reg;
                    end
                endcase
            end
            S_MODW:
            begin
                if (drsp.done)
                begin
                    rn_neg_reg <= b_neg_reg && (mod_adj != '0);
                    rn_mag_reg <= mod_adj;
                end
            end
            S_EMIT:
            begin
                if (out_take)
                begin
                    m_data_reg[31:0]  <= bad ? 32'd0 : out_num[31:0];
                    m_data_reg[62:32] <= bad ? 31'd1 : r_den_reg[30:0];
                    m_data_reg[64:63] <= bad ? CMP_LT : cmp_reg;
                    m_data_reg[66:65] <= out_status;
                    m_data_reg[71:67] <= '0;
                end
            end
            default:
            begin
                p1_reg <= p1_reg;
            end
        endcase
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    // A delivered denominator is never zero
    a_den_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[62:32] != '0)
        else $error("zero result denominator");

    // An error result is always 0/1 with compare code cleared
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tdata[66:65] != ST_OK) |->
        (m_tdata[31:0] == '0 && m_tdata[62:32] == 31'd1 && m_tdata[64:63] == CMP_LT))
        else $error("error result not cleared");

    // Divider completions arrive only in a waiting state
    a_div_done: assert property (@(posedge clk) disable iff (!rst_n)
        drsp.done |-> (state_reg == S_RGCDW || state_reg == S_RDIVNW ||
                       state_reg == S_RDIVDW || state_reg == S_MODW))
        else $error("unexpected divider completion");

endmodule
